// ===== rtl/dsc_pkg.sv =====
`timescale 1ns / 1ps
// dsc_pkg: widths, microcode op and condition codes, step addresses and the control rom
// depends on nothing; used by every module of the divisor sum/count block
package dsc_pkg;

  localparam int NUMBER_WIDTH  = 16;
  localparam int FRACTION_BITS = 16;
  localparam int COUNT_W       = 8;
  localparam int SUM_W         = 20;
  localparam int RATIO_W       = 32;

  // trial divisor runs to just past the square root of the widest number
  localparam int D_W     = NUMBER_WIDTH / 2 + 1;
  localparam int EXPO_W  = $clog2(NUMBER_WIDTH + 1);
  localparam int DIVD_W  = SUM_W + FRACTION_BITS;
  localparam int PAD_W   = DIVD_W - NUMBER_WIDTH;
  localparam int DVS_W   = (D_W > COUNT_W) ? D_W : COUNT_W;
  localparam int CNT_W   = $clog2(DIVD_W + 1);
  localparam int MUL_W   = SUM_W;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int STEP_W  = 5;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQUARE,
    OP_INIT_PRIME,
    OP_TAKE_Q,
    OP_GEO,
    OP_MUL_TAU,
    OP_MUL_SIGMA,
    OP_SET_SIGMA,
    OP_INC_D,
    OP_TAIL,
    OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_SQ_GT,
    C_DIV_BUSY,
    C_REM_NZ,
    C_REM_ZERO,
    C_REST_LE1,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    logic  gate;       // suppress op when the jump is taken
    logic  div_start;
    logic  div_ratio;
    cond_t cond;
    step_t target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic div_start;
    logic div_ratio;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic sq_gt;
    logic div_busy;
    logic rem_zero;
    logic rest_le1;
    logic out_busy;
  } stat_t;

  localparam step_t ST_WAIT    = 5'd0;
  localparam step_t ST_SQ      = 5'd1;
  localparam step_t ST_TEST    = 5'd2;
  localparam step_t ST_TRY     = 5'd3;
  localparam step_t ST_TRY_W   = 5'd4;
  localparam step_t ST_CHK     = 5'd5;
  localparam step_t ST_TAKE    = 5'd6;
  localparam step_t ST_GEO     = 5'd7;
  localparam step_t ST_GEO_W   = 5'd8;
  localparam step_t ST_AGAIN   = 5'd9;
  localparam step_t ST_MTAU    = 5'd10;
  localparam step_t ST_MSIG    = 5'd11;
  localparam step_t ST_SSIG    = 5'd12;
  localparam step_t ST_NEXT    = 5'd13;
  localparam step_t ST_TAIL    = 5'd14;
  localparam step_t ST_TAIL_M  = 5'd15;
  localparam step_t ST_TAIL_S  = 5'd16;
  localparam step_t ST_RATIO   = 5'd17;
  localparam step_t ST_RATIO_W = 5'd18;
  localparam step_t ST_OUT     = 5'd19;
  localparam step_t ST_DONE    = 5'd20;

  function automatic ucode_t ucode(input step_t s);
    ucode_t w;
    w.op        = OP_NONE;
    w.gate      = 1'b0;
    w.div_start = 1'b0;
    w.div_ratio = 1'b0;
    w.cond      = C_NEVER;
    w.target    = ST_WAIT;
    case (s)
      ST_WAIT: begin
        w.op = OP_LOAD; w.gate = 1'b1; w.cond = C_NO_INPUT; w.target = ST_WAIT;
      end
      ST_SQ:    w.op = OP_SQUARE;
      ST_TEST: begin
        w.cond = C_SQ_GT; w.target = ST_TAIL;
      end
      ST_TRY:   w.div_start = 1'b1;
      ST_TRY_W: begin
        w.cond = C_DIV_BUSY; w.target = ST_TRY_W;
      end
      ST_CHK: begin
        w.op = OP_INIT_PRIME; w.gate = 1'b1; w.cond = C_REM_NZ; w.target = ST_NEXT;
      end
      ST_TAKE:  w.op = OP_TAKE_Q;
      ST_GEO: begin
        w.op = OP_GEO; w.div_start = 1'b1;
      end
      ST_GEO_W: begin
        w.cond = C_DIV_BUSY; w.target = ST_GEO_W;
      end
      ST_AGAIN: begin
        w.cond = C_REM_ZERO; w.target = ST_TAKE;
      end
      ST_MTAU:  w.op = OP_MUL_TAU;
      ST_MSIG:  w.op = OP_MUL_SIGMA;
      ST_SSIG:  w.op = OP_SET_SIGMA;
      ST_NEXT: begin
        w.op = OP_INC_D; w.cond = C_ALWAYS; w.target = ST_SQ;
      end
      ST_TAIL: begin
        w.cond = C_REST_LE1; w.target = ST_RATIO;
      end
      ST_TAIL_M: w.op = OP_TAIL;
      ST_TAIL_S: w.op = OP_SET_SIGMA;
      ST_RATIO: begin
        w.div_start = 1'b1; w.div_ratio = 1'b1;
      end
      ST_RATIO_W: begin
        w.cond = C_DIV_BUSY; w.target = ST_RATIO_W;
      end
      ST_OUT: begin
        w.op = OP_OUT; w.gate = 1'b1; w.cond = C_OUT_BUSY; w.target = ST_OUT;
      end
      ST_DONE: begin
        w.cond = C_ALWAYS; w.target = ST_WAIT;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/divisor_sum_count_ratio_top.sv =====
`timescale 1ns / 1ps
// divisor_sum_count_ratio_top: divisor count, divisor sum and their ratio for one number
// depends on dsc_pkg, dsc_seq and dsc_dp
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid, in_ready, in_number                      | word in
//  out     | out_valid, out_ready, out_divisor_count,           | word out
//          | out_divisor_sum, out_ratio                         |
//
// one word at a time: a new word is taken only when the sequencer is back at its wait step
// each trial divisor runs the one-bit-per-cycle restoring divider over the 16 rest bits,
// then waits for it to finish before the remainder test; every divided-out factor runs it again
// and each prime found then passes through the tau and sigma update steps
// the slowest input is a prime near 2^16; the final ratio runs the divider over all 36 dividend bits
// synchronous active-low reset returns the step counter to wait and empties the output
// a held output word stalls only the last step; the next word is taken after the done step
module divisor_sum_count_ratio_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dsc_pkg::NUMBER_WIDTH-1:0] in_number,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dsc_pkg::COUNT_W-1:0]      out_divisor_count,
  output logic [dsc_pkg::SUM_W-1:0]        out_divisor_sum,
  output logic [dsc_pkg::RATIO_W-1:0]      out_ratio
);

  // control word after jump gating, and the flags the jumps test
  dsc_pkg::ctl_t  ctl;
  dsc_pkg::stat_t stat;

  // program counter, control rom and branch logic
  dsc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctl      (ctl),
    .in_ready (in_ready)
  );

  // rest, trial divisor, tau, sigma, geometric sum, shared multiplier and divider
  dsc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .in_number         (in_number),
    .out_ready         (out_ready),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_divisor_count (out_divisor_count),
    .out_divisor_sum   (out_divisor_sum),
    .out_ratio         (out_ratio)
  );

endmodule

// ===== rtl/dsc_seq.sv =====
`timescale 1ns / 1ps
// dsc_seq: step counter, control rom fetch and conditional jumps
// depends on dsc_pkg
module dsc_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  dsc_pkg::stat_t stat,
  output dsc_pkg::ctl_t  ctl,
  output logic           in_ready
);

  dsc_pkg::step_t  pc_r;
  dsc_pkg::step_t  pc_nxt;
  dsc_pkg::ucode_t uw;
  logic            taken;
  logic            run;

  always_comb begin
    uw = dsc_pkg::ucode(pc_r);
    case (uw.cond)
      dsc_pkg::C_NEVER:    taken = 1'b0;
      dsc_pkg::C_ALWAYS:   taken = 1'b1;
      dsc_pkg::C_NO_INPUT: taken = !in_valid;
      dsc_pkg::C_SQ_GT:    taken = stat.sq_gt;
      dsc_pkg::C_DIV_BUSY: taken = stat.div_busy;
      dsc_pkg::C_REM_NZ:   taken = !stat.rem_zero;
      dsc_pkg::C_REM_ZERO: taken = stat.rem_zero;
      dsc_pkg::C_REST_LE1: taken = stat.rest_le1;
      dsc_pkg::C_OUT_BUSY: taken = stat.out_busy;
      default:             taken = 1'b0;
    endcase
    run           = !(uw.gate && taken);
    pc_nxt        = taken ? uw.target : pc_r + dsc_pkg::step_t'(1);
    ctl.op        = run ? uw.op : dsc_pkg::OP_NONE;
    ctl.div_start = run && uw.div_start;
    ctl.div_ratio = uw.div_ratio;
  end

  assign in_ready = (pc_r == dsc_pkg::ST_WAIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= dsc_pkg::ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/dsc_div.sv =====
`timescale 1ns / 1ps
// dsc_div: restoring divider, one quotient bit per cycle
// depends on dsc_pkg; shared by the trial remainder test and the final ratio
module dsc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       ratio_mode,
  input  logic [dsc_pkg::DIVD_W-1:0] dividend,
  input  logic [dsc_pkg::DVS_W-1:0]  divisor,
  output logic                       busy,
  output logic [dsc_pkg::DIVD_W-1:0] quo,
  output logic [dsc_pkg::DVS_W-1:0]  rem
);

  logic [dsc_pkg::DIVD_W-1:0] quo_r;
  logic [dsc_pkg::DVS_W-1:0]  rem_r;
  logic [dsc_pkg::DVS_W-1:0]  dvs_r;
  logic [dsc_pkg::CNT_W-1:0]  cnt_r;
  logic [dsc_pkg::DVS_W:0]    shifted;
  logic [dsc_pkg::DVS_W:0]    diff;
  logic                       ge;

  always_comb begin
    shifted = {rem_r, quo_r[dsc_pkg::DIVD_W-1]};
    ge      = (shifted >= {1'b0, dvs_r});
    diff    = shifted - {1'b0, dvs_r};
  end

  // trial dividend sits in the top bits, so only its own width of steps is run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= ratio_mode ? dsc_pkg::CNT_W'(dsc_pkg::DIVD_W)
                          : dsc_pkg::CNT_W'(dsc_pkg::NUMBER_WIDTH);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - dsc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[dsc_pkg::DIVD_W-2:0], ge};
      rem_r <= ge ? diff[dsc_pkg::DVS_W-1:0] : shifted[dsc_pkg::DVS_W-1:0];
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/dsc_dp.sv =====
`timescale 1ns / 1ps
// dsc_dp: working registers, shared multiplier, divider and output register
// depends on dsc_pkg and dsc_div
module dsc_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dsc_pkg::ctl_t                    ctl,
  input  logic [dsc_pkg::NUMBER_WIDTH-1:0] in_number,
  input  logic                             out_ready,
  output dsc_pkg::stat_t                   stat,
  output logic                             out_valid,
  output logic [dsc_pkg::COUNT_W-1:0]      out_divisor_count,
  output logic [dsc_pkg::SUM_W-1:0]        out_divisor_sum,
  output logic [dsc_pkg::RATIO_W-1:0]      out_ratio
);

  logic [dsc_pkg::NUMBER_WIDTH-1:0] rest_r;
  logic [dsc_pkg::D_W-1:0]          d_r;
  logic [dsc_pkg::COUNT_W-1:0]      tau_r;
  logic [dsc_pkg::SUM_W-1:0]        sigma_r;
  logic [dsc_pkg::EXPO_W-1:0]       expo_r;
  logic [dsc_pkg::NUMBER_WIDTH-1:0] term_r;
  logic [dsc_pkg::SUM_W-1:0]        geo_r;
  logic [dsc_pkg::PROD_W-1:0]       prod_r;
  logic [dsc_pkg::PROD_W-1:0]       prod_nxt;
  logic [dsc_pkg::MUL_W-1:0]        mul_a;
  logic [dsc_pkg::MUL_W-1:0]        mul_b;
  logic [dsc_pkg::COUNT_W-1:0]      count_r;
  logic [dsc_pkg::SUM_W-1:0]        sum_r;
  logic [dsc_pkg::RATIO_W-1:0]      ratio_r;
  logic                             out_valid_r;

  logic [dsc_pkg::DIVD_W-1:0] div_dividend;
  logic [dsc_pkg::DVS_W-1:0]  div_divisor;
  logic                       div_busy;
  logic [dsc_pkg::DIVD_W-1:0] div_quo;
  logic [dsc_pkg::DVS_W-1:0]  div_rem;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.op)
      dsc_pkg::OP_SQUARE: begin
        mul_a = dsc_pkg::MUL_W'(d_r);
        mul_b = dsc_pkg::MUL_W'(d_r);
      end
      dsc_pkg::OP_TAKE_Q: begin
        mul_a = dsc_pkg::MUL_W'(term_r);
        mul_b = dsc_pkg::MUL_W'(d_r);
      end
      dsc_pkg::OP_MUL_TAU: begin
        mul_a = dsc_pkg::MUL_W'(tau_r);
        mul_b = dsc_pkg::MUL_W'(expo_r) + dsc_pkg::MUL_W'(1);
      end
      dsc_pkg::OP_MUL_SIGMA: begin
        mul_a = sigma_r;
        mul_b = geo_r;
      end
      dsc_pkg::OP_TAIL: begin
        mul_a = sigma_r;
        mul_b = dsc_pkg::MUL_W'(rest_r) + dsc_pkg::MUL_W'(1);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = dsc_pkg::PROD_W'(mul_a) * dsc_pkg::PROD_W'(mul_b);
  end

  // trial: rest aligned to the top; ratio: sigma scaled by the fraction bits
  always_comb begin
    if (ctl.div_ratio) begin
      div_dividend = dsc_pkg::DIVD_W'(sigma_r) << dsc_pkg::FRACTION_BITS;
      div_divisor  = dsc_pkg::DVS_W'(tau_r);
    end else begin
      div_dividend = dsc_pkg::DIVD_W'(rest_r) << dsc_pkg::PAD_W;
      div_divisor  = dsc_pkg::DVS_W'(d_r);
    end
  end

  dsc_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (ctl.div_start),
    .ratio_mode (ctl.div_ratio),
    .dividend   (div_dividend),
    .divisor    (div_divisor),
    .busy       (div_busy),
    .quo        (div_quo),
    .rem        (div_rem)
  );

  always_ff @(posedge clk) begin
    case (ctl.op)
      dsc_pkg::OP_LOAD: begin
        rest_r  <= in_number;
        d_r     <= dsc_pkg::D_W'(2);
        tau_r   <= dsc_pkg::COUNT_W'(1);
        sigma_r <= dsc_pkg::SUM_W'(1);
      end
      dsc_pkg::OP_SQUARE: prod_r <= prod_nxt;
      dsc_pkg::OP_INIT_PRIME: begin
        expo_r <= '0;
        term_r <= dsc_pkg::NUMBER_WIDTH'(1);
        geo_r  <= dsc_pkg::SUM_W'(1);
      end
      dsc_pkg::OP_TAKE_Q: begin
        rest_r <= div_quo[dsc_pkg::NUMBER_WIDTH-1:0];
        expo_r <= expo_r + dsc_pkg::EXPO_W'(1);
        prod_r <= prod_nxt;
      end
      dsc_pkg::OP_GEO: begin
        term_r <= prod_r[dsc_pkg::NUMBER_WIDTH-1:0];
        geo_r  <= geo_r + prod_r[dsc_pkg::SUM_W-1:0];
      end
      dsc_pkg::OP_MUL_TAU: prod_r <= prod_nxt;
      dsc_pkg::OP_MUL_SIGMA: begin
        tau_r  <= prod_r[dsc_pkg::COUNT_W-1:0];
        prod_r <= prod_nxt;
      end
      dsc_pkg::OP_SET_SIGMA: sigma_r <= prod_r[dsc_pkg::SUM_W-1:0];
      dsc_pkg::OP_INC_D: d_r <= d_r + dsc_pkg::D_W'(1);
      dsc_pkg::OP_TAIL: begin
        tau_r  <= tau_r << 1;
        prod_r <= prod_nxt;
      end
      dsc_pkg::OP_OUT: begin
        count_r <= tau_r;
        sum_r   <= sigma_r;
        ratio_r <= (|div_quo[dsc_pkg::DIVD_W-1:dsc_pkg::RATIO_W]) ? '1
                   : div_quo[dsc_pkg::RATIO_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.op == dsc_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    stat.sq_gt    = (prod_r > dsc_pkg::PROD_W'(rest_r));
    stat.div_busy = div_busy;
    stat.rem_zero = (div_rem == '0);
    stat.rest_le1 = (rest_r <= dsc_pkg::NUMBER_WIDTH'(1));
    stat.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_divisor_count = count_r;
  assign out_divisor_sum   = sum_r;
  assign out_ratio         = ratio_r;

endmodule

// ===== rtl/dsc_chk.sv =====
`timescale 1ns / 1ps
// dsc_chk: port-level checks on the divisor sum/count block, bound to the top level
// depends on dsc_pkg and divisor_sum_count_ratio_top
module dsc_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [dsc_pkg::COUNT_W-1:0]      out_divisor_count,
  input logic [dsc_pkg::SUM_W-1:0]        out_divisor_sum,
  input logic [dsc_pkg::RATIO_W-1:0]      out_ratio
);

  // held output word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ratio)
      && $stable(out_divisor_sum) && $stable(out_divisor_count))
    else $error("output word changed while stalled");

  // reset leaves the block ready and the output empty
  a_reset: assert property (@(posedge clk) !rst_n |=> in_ready && !out_valid)
    else $error("bad state after reset");

  // one word at a time
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  // sigma is a sum of tau positive divisors
  a_sum_ge_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_divisor_count != '0
      && dsc_pkg::SUM_W'(out_divisor_count) <= out_divisor_sum)
    else $error("divisor sum below divisor count");

  // a single divisor means the number one: ratio exactly one
  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divisor_count == dsc_pkg::COUNT_W'(1)
      |-> out_divisor_sum == dsc_pkg::SUM_W'(1)
        && out_ratio == (dsc_pkg::RATIO_W'(1) << dsc_pkg::FRACTION_BITS))
    else $error("unit result inconsistent");

endmodule

bind divisor_sum_count_ratio_top dsc_chk u_chk (.*);

// ===== sim/dsc_checker.sv =====
`timescale 1ns / 1ps
// dsc_checker: watches both word channels of the divisor sum/count block and checks every result
// depends on dsc_pkg for field widths and the fraction bit count
module dsc_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [dsc_pkg::NUMBER_WIDTH-1:0] in_number,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [dsc_pkg::COUNT_W-1:0]      out_divisor_count,
  input  logic [dsc_pkg::SUM_W-1:0]        out_divisor_sum,
  input  logic [dsc_pkg::RATIO_W-1:0]      out_ratio,
  output int                               words_awaited,
  output int                               mismatch_count
);

  typedef struct packed {
    logic [dsc_pkg::NUMBER_WIDTH-1:0] number;
    logic [dsc_pkg::COUNT_W-1:0]      divisor_count;
    logic [dsc_pkg::SUM_W-1:0]        divisor_sum;
    logic [dsc_pkg::RATIO_W-1:0]      ratio;
  } divisor_stats_t;

  divisor_stats_t awaited_stats[$];
  int             pending  = 0;
  int             failures = 0;

  assign words_awaited  = pending;
  assign mismatch_count = failures;

  // trial division with geometric sums, all in 64 bits, saturated to the port widths
  function automatic divisor_stats_t divisor_stats(input logic [dsc_pkg::NUMBER_WIDTH-1:0] n);
    logic [63:0] rest;
    logic [63:0] tau;
    logic [63:0] sigma;
    logic [63:0] d;
    logic [63:0] expo;
    logic [63:0] power;
    logic [63:0] geo;
    logic [63:0] quotient;
    divisor_stats_t s;
    rest  = 64'(n);
    tau   = 64'd1;
    sigma = 64'd1;
    for (d = 64'd2; d * d <= rest; d++) begin
      if (rest % d == 0) begin
        expo  = 0;
        power = 1;
        geo   = 1;
        while (rest % d == 0) begin
          rest  = rest / d;
          expo  = expo + 1;
          power = power * d;
          geo   = geo + power;
        end
        tau   = tau * (expo + 1);
        sigma = sigma * geo;
      end
    end
    if (rest > 1) begin
      tau   = tau * 2;
      sigma = sigma * (rest + 1);
    end
    quotient = (sigma << dsc_pkg::FRACTION_BITS) / tau;
    s.number        = n;
    s.divisor_count = ((tau >> dsc_pkg::COUNT_W) != 0) ? '1 : tau[dsc_pkg::COUNT_W-1:0];
    s.divisor_sum   = ((sigma >> dsc_pkg::SUM_W) != 0) ? '1 : sigma[dsc_pkg::SUM_W-1:0];
    s.ratio = ((quotient >> dsc_pkg::RATIO_W) != 0) ? '1 : quotient[dsc_pkg::RATIO_W-1:0];
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want, input logic [63:0] n);
    $display("%0t checker: %s for number %0d, got %0d, want %0d", $realtime, what, n, got, want);
    failures++;
  endtask

  always @(posedge clk) begin
    divisor_stats_t want;
    if (!rst_n) begin
      awaited_stats.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_stats.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_divisor_count), 0, 0);
        end else begin
          want = awaited_stats.pop_front();
          if (out_divisor_count !== want.divisor_count)
            report_mismatch("divisor_count", 64'(out_divisor_count),
                            64'(want.divisor_count), 64'(want.number));
          if (out_divisor_sum !== want.divisor_sum)
            report_mismatch("divisor_sum", 64'(out_divisor_sum),
                            64'(want.divisor_sum), 64'(want.number));
          if (out_ratio !== want.ratio)
            report_mismatch("ratio", 64'(out_ratio), 64'(want.ratio), 64'(want.number));
        end
      end
      if (in_valid && in_ready)
        awaited_stats.push_back(divisor_stats(in_number));
    end
    // published after the edge so the stimulus side reads a settled value
    pending <= awaited_stats.size();
  end

  final begin
    if (awaited_stats.size() != 0)
      $display("checker: %0d results never arrived", awaited_stats.size());
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for divisor_sum_count_ratio_top
// depends on dsc_pkg, the block itself and dsc_checker, which does all the checking
module tb_top;

  localparam int NW          = dsc_pkg::NUMBER_WIDTH;
  localparam int RANDOM_WORDS = 100;
  // the limit covers the slowest correct run of 121 words plus gaps and stalls
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int SETTLE_CYCLES = 100;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [NW-1:0]                in_number = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [dsc_pkg::COUNT_W-1:0]  out_divisor_count;
  logic [dsc_pkg::SUM_W-1:0]    out_divisor_sum;
  logic [dsc_pkg::RATIO_W-1:0]  out_ratio;

  int   words_awaited;
  int   mismatch_count;
  int   cycle_count = 0;
  int   ready_hold = 0;
  logic ready_steady = 1'b0;

  // corner numbers: zero, one, small primes and squares right at the d*d boundary,
  // prime powers, the largest prime below 2^16, highly composite values and bit patterns
  logic [NW-1:0] corner_numbers [21] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'd25, 16'd49, 16'd6, 16'd12,
    16'd32768, 16'd59049, 16'd63001, 16'd65521, 16'd65534, 16'd65535,
    16'd55440, 16'd45360, 16'd30030, 16'hAAAA, 16'h5555
  };

  int small_primes [10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 251};

  divisor_sum_count_ratio_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_number         (in_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_divisor_count (out_divisor_count),
    .out_divisor_sum   (out_divisor_sum),
    .out_ratio         (out_ratio)
  );

  dsc_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_number         (in_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_divisor_count (out_divisor_count),
    .out_divisor_sum   (out_divisor_sum),
    .out_ratio         (out_ratio),
    .words_awaited     (words_awaited),
    .mismatch_count    (mismatch_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side back-pressure: mostly ready, short stalls, now and then a long one;
  // held high throughout the steady stretches
  always @(posedge clk) begin
    int roll;
    roll = $urandom_range(0, 99);
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (ready_steady || roll < 70) begin
      out_ready <= 1'b1;
    end else if (roll < 95) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 4);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(10, 60);
    end
  end

  // present one word and hold it until taken, then maybe leave a gap;
  // with no gap valid simply stays high for the next word
  task automatic send_number(input logic [NW-1:0] n, input bit with_gaps);
    int roll;
    int gap;
    in_valid  <= 1'b1;
    in_number <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    roll = $urandom_range(0, 99);
    gap  = 0;
    if (with_gaps) begin
      if (roll >= 90)      gap = $urandom_range(50, 2000);
      else if (roll >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender holds off until every expected result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_awaited != 0);
  endtask

  // mix of full range values, small values, products of small primes and values near the top
  function automatic logic [NW-1:0] pick_number();
    int roll;
    int product;
    int p;
    roll = $urandom_range(0, 99);
    if (roll < 40) return NW'($urandom_range(1, 65535));
    if (roll < 65) return NW'($urandom_range(1, 2047));
    if (roll < 85) begin
      product = 1;
      repeat ($urandom_range(1, 7)) begin
        p = small_primes[$urandom_range(0, 9)];
        if (product * p <= 65535) product = product * p;
      end
      return NW'(product);
    end
    if (roll < 95) return NW'($urandom_range(65000, 65535) | 1);
    // rare extremes, zero among them
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return NW'(1);
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners, the first few with no idling on either side
    ready_steady <= 1'b1;
    for (int i = 0; i < 21; i++) begin
      if (i == 6) ready_steady <= 1'b0;
      send_number(corner_numbers[i], i >= 6);
    end
    drain_results();

    // random words: a steady stretch first, then idling on both sides,
    // with a full drain part way through
    ready_steady <= 1'b1;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 30) ready_steady <= 1'b0;
      if (i == 70) drain_results();
      send_number(pick_number(), i >= 30);
    end
    drain_results();

    // catch anything that shows up late
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && words_awaited == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
